>>> sv/hvac_bus_pkg.sv
`timescale 1ns / 1ps

package hvac_bus_pkg;

    // frame layout
    localparam int unsigned FRAME_LEN = 14;
    localparam int unsigned STORE_LEN = FRAME_LEN - 1;
    localparam int unsigned XOR_FIRST = 1;
    localparam int unsigned XOR_LAST  = 11;

    localparam logic [7:0]  START_BYTE  = 8'h32;
    localparam logic [7:0]  END_BYTE    = 8'h34;
    localparam logic [17:0] TEMP_OFFSET = 18'd55;
    localparam logic [4:0]  STOP_DIR_RESET = 5'd31;

    // command codes
    localparam logic [7:0] CMD_STATE    = 8'h20;
    localparam logic [7:0] CMD_CONTROL  = 8'hC0;
    localparam logic [7:0] CMD_OUTDOOR  = 8'hC1;
    localparam logic [7:0] CMD_CTRL_ST  = 8'hC6;
    localparam logic [7:0] CMD_FLAGS    = 8'hF0;
    localparam logic [7:0] CMD_VALVES   = 8'hF1;
    localparam logic [7:0] CMD_POWER    = 8'hF3;

    // register indexes
    localparam logic REG_STOP_DIR = 1'b0;

    typedef enum logic [2:0] {
        ST_OK           = 3'd0,
        ST_BAD_START    = 3'd1,
        ST_BAD_LENGTH   = 3'd2,
        ST_BAD_END      = 3'd3,
        ST_BAD_CHECKSUM = 3'd4
    } t_status;

    // frame bytes 1 to 12 as kept for decoding
    typedef logic [12:1][7:0] t_payload;

    typedef struct packed {
        logic        last_of_run;
        logic signed [17:0] field_value;
        logic [3:0]  field_index;
        logic [7:0]  command_code;
        logic [7:0]  dest_address;
        logic [7:0]  source_address;
        logic        is_header;
        t_status     status;
    } t_result;

    function automatic logic [17:0] f_temp(input logic [7:0] b);
        f_temp = {10'd0, b} - TEMP_OFFSET;
    endfunction

    function automatic logic [17:0] f_raw(input logic [7:0] b);
        f_raw = {10'd0, b};
    endfunction

    function automatic logic [17:0] f_flag(input logic b);
        f_flag = {17'd0, b};
    endfunction

    function automatic logic [3:0] f_field_count(input logic [7:0] cmd);
        logic [3:0] n;
        unique case (cmd)
            CMD_STATE:   n = 4'd8;
            CMD_CONTROL: n = 4'd8;
            CMD_OUTDOOR: n = 4'd1;
            CMD_CTRL_ST: n = 4'd1;
            CMD_FLAGS:   n = 4'd10;
            CMD_VALVES:  n = 4'd4;
            CMD_POWER:   n = 4'd5;
            default:     n = 4'd9;
        endcase
        f_field_count = n;
    endfunction

    function automatic logic signed [17:0] f_field_value(
        input t_payload   d,
        input logic [3:0] k,
        input logic [4:0] stop_dir
    );
        logic [4:0]  wind;
        logic [15:0] prod;
        logic [17:0] v;
        wind = (d[7][7:3] == 5'd0) ? stop_dir : d[7][7:3];
        prod = 16'(d[8]) * 16'(d[9]);
        v    = '0;
        unique case (d[3])
            CMD_STATE: begin
                unique case (k)
                    4'd0:    v = f_temp(d[4]);
                    4'd1:    v = f_temp(d[5]);
                    4'd2:    v = f_temp(d[6]);
                    4'd3:    v = {13'd0, wind};
                    4'd4:    v = {15'd0, d[7][2:0]};
                    4'd5:    v = {12'd0, d[8][5:0]};
                    4'd6:    v = f_flag(d[8][7]);
                    4'd7:    v = f_temp(d[11]);
                    default: v = '0;
                endcase
            end
            CMD_CONTROL: begin
                unique case (k)
                    4'd0:    v = f_raw(d[4]);
                    4'd1:    v = f_flag(d[6][7]);
                    4'd2:    v = f_flag(d[6][5]);
                    4'd3:    v = f_flag(d[6][2]);
                    4'd4:    v = f_flag(|d[7][1:0]);
                    4'd5:    v = f_temp(d[8]);
                    4'd6:    v = f_temp(d[10]);
                    4'd7:    v = f_temp(d[11]);
                    default: v = '0;
                endcase
            end
            CMD_OUTDOOR: v = f_temp(d[8]);
            CMD_CTRL_ST: v = f_raw(d[4]);
            CMD_FLAGS: begin
                unique case (k)
                    4'd0:    v = f_flag(d[4][7]);
                    4'd1:    v = f_flag(d[4][6]);
                    4'd2:    v = f_flag(d[4][5]);
                    4'd3:    v = f_flag(d[4][4]);
                    4'd4:    v = f_flag(d[4][3]);
                    4'd5:    v = f_raw(d[5]);
                    4'd6:    v = f_raw(d[6]);
                    4'd7:    v = f_raw(d[7]);
                    4'd8:    v = f_flag(|d[8][1:0]);
                    4'd9:    v = f_raw(d[10]);
                    default: v = '0;
                endcase
            end
            CMD_VALVES: begin
                unique case (k)
                    4'd0:    v = {2'd0, d[4], d[5]};
                    4'd1:    v = {2'd0, d[6], d[7]};
                    4'd2:    v = {2'd0, d[8], d[9]};
                    4'd3:    v = {2'd0, d[10], d[11]};
                    default: v = '0;
                endcase
            end
            CMD_POWER: begin
                unique case (k)
                    4'd0:    v = f_raw(d[4]);
                    4'd1:    v = f_raw(d[5]);
                    4'd2:    v = f_raw(d[8]);
                    4'd3:    v = {9'd0, d[9], 1'b0};
                    4'd4:    v = {1'b0, prod, 1'b0};
                    default: v = '0;
                endcase
            end
            default: begin
                unique case (k)
                    4'd0:    v = f_raw(d[4]);
                    4'd1:    v = f_raw(d[5]);
                    4'd2:    v = f_raw(d[6]);
                    4'd3:    v = f_raw(d[7]);
                    4'd4:    v = f_raw(d[8]);
                    4'd5:    v = f_raw(d[9]);
                    4'd6:    v = f_raw(d[10]);
                    4'd7:    v = f_raw(d[11]);
                    4'd8:    v = f_raw(d[12]);
                    default: v = '0;
                endcase
            end
        endcase
        f_field_value = $signed(v);
    endfunction

endpackage

>>> sv/hvac_bus_frame_decoder_unit.sv
// order: the header or status result goes through the emitter snapshot and the output register,
//   in that order; field results follow one per cycle while i_m_tready is high
// throughput: one byte per cycle in, one result per cycle out while i_m_tready is high;
//   a last byte waits only while the previous frame's burst (up to 11 results) drains
// reset: i_rst_n low at a rising edge clears byte count, checksum, burst and output
//   valid, and sets stop_direction_code to 31; the byte store is not cleared
`timescale 1ns / 1ps

module hvac_bus_frame_decoder_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input stream
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [7:0]  i_s_tdata,    // [7:0] rx_byte
    input  logic        i_s_tlast,    // frame_end
    // result stream
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [55:0] o_m_tdata,    // [2:0] status, [10:3] source_address,
                                      // [18:11] dest_address, [26:19] command_code,
                                      // [30:27] field_index, [48:31] field_value,
                                      // [55:49] zero
    output logic        o_m_tuser,    // [0] is_header
    output logic        o_m_tlast,    // last_of_run
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import hvac_bus_pkg::*;

    // configuration register
    logic [4:0] r_stop_dir;

    // frame collection: bytes 0 to 12 of the frame being received
    logic [7:0] r_frame [0:STORE_LEN-1];
    logic [3:0] r_count, n_count;
    logic [7:0] r_xor, n_xor;

    // burst emitter: snapshot of a finished frame
    logic       r_em_active, n_em_active;
    logic [3:0] r_em_idx, n_em_idx;
    t_status    r_em_status, n_em_status;
    t_payload   r_em_bytes;

    // output register
    logic       r_out_valid, n_out_valid;
    t_result    r_out;

    logic       in_xfer;
    logic       frame_done;
    logic       out_load;
    logic       em_last;
    logic       em_free;
    logic [7:0] first_byte;
    logic [3:0] count_inc;
    t_status    frame_status;
    logic [3:0] field_count;
    t_result    em_result;

    // ---------------------------------------------------------------
    // configuration port: always ready, one register at word 0
    // ---------------------------------------------------------------
    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_STOP_DIR) ? {27'd0, r_stop_dir} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stop_dir <= STOP_DIR_RESET;
        end else if (psel && penable && pwrite && pready && paddr[2] == REG_STOP_DIR) begin
            r_stop_dir <= pwdata[4:0];
        end
    end

    // ---------------------------------------------------------------
    // handshakes
    // ---------------------------------------------------------------
    // the output register takes a new result when empty or being drained
    assign out_load = !r_out_valid || i_m_tready;

    // the emitter can take a new snapshot once its last result moves out
    assign field_count = f_field_count(r_em_bytes[3]);
    assign em_last     = (r_em_status != ST_OK) || (r_em_idx == field_count);
    assign em_free     = !r_em_active || (out_load && em_last);

    // ordinary bytes are always taken; a last byte needs a free emitter
    assign o_s_tready = !i_s_tlast || em_free;
    assign in_xfer    = i_s_tvalid && o_s_tready;
    assign frame_done = in_xfer && i_s_tlast;

    // ---------------------------------------------------------------
    // frame checks on the transaction that carries the last byte
    // ---------------------------------------------------------------
    // byte 0 comes from this transaction when it is the only byte
    assign first_byte = (r_count == 4'd0) ? i_s_tdata : r_frame[0];
    assign count_inc  = (r_count == 4'hF) ? r_count : r_count + 4'd1;

    always_comb begin
        // with exactly 14 bytes the current byte is byte 13 and byte 12 is stored
        priority if (first_byte != START_BYTE) begin
            frame_status = ST_BAD_START;
        end else if (count_inc != 4'(FRAME_LEN)) begin
            frame_status = ST_BAD_LENGTH;
        end else if (i_s_tdata != END_BYTE) begin
            frame_status = ST_BAD_END;
        end else if (r_frame[12] != r_xor) begin
            frame_status = ST_BAD_CHECKSUM;
        end else begin
            frame_status = ST_OK;
        end
    end

    // byte store, no reset: entries are only used after being written this frame
    always_ff @(posedge i_clk) begin
        if (in_xfer && r_count < 4'(STORE_LEN)) begin
            r_frame[r_count] <= i_s_tdata;
        end
    end

    always_comb begin
        n_count = r_count;
        n_xor   = r_xor;
        if (in_xfer) begin
            if (i_s_tlast) begin
                n_count = '0;
                n_xor   = '0;
            end else begin
                n_count = count_inc;
                if (r_count >= 4'(XOR_FIRST) && r_count <= 4'(XOR_LAST)) begin
                    n_xor = r_xor ^ i_s_tdata;
                end
            end
        end
    end

    // ---------------------------------------------------------------
    // result selection for the current burst position
    // ---------------------------------------------------------------
    always_comb begin
        em_result        = '0;
        em_result.status = r_em_status;
        if (r_em_status != ST_OK) begin
            // failed frame: a single status result with zero payload
            em_result.is_header   = 1'b1;
            em_result.last_of_run = 1'b1;
        end else begin
            em_result.source_address = r_em_bytes[1];
            em_result.dest_address   = r_em_bytes[2];
            em_result.command_code   = r_em_bytes[3];
            em_result.last_of_run    = em_last;
            if (r_em_idx == 4'd0) begin
                em_result.is_header = 1'b1;
            end else begin
                em_result.field_index = r_em_idx - 4'd1;
                em_result.field_value =
                    f_field_value(r_em_bytes, r_em_idx - 4'd1, r_stop_dir);
            end
        end
    end

    // ---------------------------------------------------------------
    // emitter and output register next state
    // ---------------------------------------------------------------
    always_comb begin
        n_em_active = r_em_active;
        n_em_idx    = r_em_idx;
        n_em_status = r_em_status;
        n_out_valid = r_out_valid;

        if (out_load) begin
            n_out_valid = r_em_active;
            if (r_em_active) begin
                if (em_last) begin
                    n_em_active = 1'b0;
                end else begin
                    n_em_idx = r_em_idx + 4'd1;
                end
            end
        end

        // a new frame snapshot wins over the retiring burst
        if (frame_done) begin
            n_em_active = 1'b1;
            n_em_idx    = '0;
            n_em_status = frame_status;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_xor       <= '0;
            r_em_active <= 1'b0;
            r_em_idx    <= '0;
            r_em_status <= ST_OK;
            r_out_valid <= 1'b0;
        end else begin
            r_count     <= n_count;
            r_xor       <= n_xor;
            r_em_active <= n_em_active;
            r_em_idx    <= n_em_idx;
            r_em_status <= n_em_status;
            r_out_valid <= n_out_valid;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (frame_done) begin
            for (int i = 1; i <= 12; i++) begin
                r_em_bytes[i] <= r_frame[i];
            end
        end
        if (out_load && r_em_active) begin
            r_out <= em_result;
        end
    end

    // ---------------------------------------------------------------
    // output packing
    // ---------------------------------------------------------------
    assign o_m_tvalid = r_out_valid;
    assign o_m_tuser  = r_out.is_header;
    assign o_m_tlast  = r_out.last_of_run;
    assign o_m_tdata  = {7'd0,
                         r_out.field_value,
                         r_out.field_index,
                         r_out.command_code,
                         r_out.dest_address,
                         r_out.source_address,
                         r_out.status};

    // ---------------------------------------------------------------
    // assertions
    // ---------------------------------------------------------------
    // a last byte is only taken when the emitter can hold its snapshot
    a_snapshot_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        frame_done |-> em_free)
        else $error("frame end taken while burst still pending");

    // the burst position never passes the longest field list
    a_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_em_active |-> r_em_idx <= 4'd10)
        else $error("burst index out of range");

    // a failed frame yields a lone header marked last
    a_status_alone: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tdata[2:0] != ST_OK |-> o_m_tuser && o_m_tlast)
        else $error("status result not a lone header");

    // field results only come from good frames
    a_field_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !o_m_tuser |-> o_m_tdata[2:0] == ST_OK)
        else $error("field result with failed status");

endmodule
